// ----- design/b2pb_pkg.sv -----
package b2pb_pkg;

  localparam int unsigned VALUE_W       = 64;
  localparam int unsigned COUNT_W       = 4;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned DIGIT_W       = 4;
  localparam int unsigned MaxBytesDef   = 10;

  // Binary bits consumed by the converter in one clock cycle.
  localparam int unsigned BITS_PER_STEP = 8;
  localparam int unsigned DAB_STEPS     = VALUE_W / BITS_PER_STEP;
  localparam int unsigned STEP_W        = (DAB_STEPS > 1) ? $clog2(DAB_STEPS) : 1;

  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } item_t;

endpackage

// ----- design/b2pb_front.sv -----
module b2pb_front #(
  parameter int unsigned MAX_BYTES = b2pb_pkg::MaxBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [b2pb_pkg::VALUE_W-1:0] value_i,
  input  logic [b2pb_pkg::COUNT_W-1:0] byte_count_i,
  output logic                         q_valid_o,
  output b2pb_pkg::item_t              q_item_o,
  input  logic                         q_take_i
);

  b2pb_pkg::item_t                    entry_q [b2pb_pkg::QUEUE_DEPTH];
  logic [b2pb_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [b2pb_pkg::QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [b2pb_pkg::QCNT_W-1:0]        cnt_q, cnt_d;
  logic [b2pb_pkg::COUNT_W-1:0]       count_sat;
  logic                               wr_en;
  logic                               rd_en;

  assign full      = (cnt_q == b2pb_pkg::QCNT_W'(b2pb_pkg::QUEUE_DEPTH));
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = entry_q[rd_ptr_q];

  // Counts above the buffer size are clamped to it.
  assign count_sat = (int'(byte_count_i) > MAX_BYTES) ?
                     b2pb_pkg::COUNT_W'(MAX_BYTES) : byte_count_i;

  // A beat with a zero byte count is taken but never queued.
  assign wr_en = push && !full && (byte_count_i != '0);
  assign rd_en = q_take_i && q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == b2pb_pkg::QPTR_W'(b2pb_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == b2pb_pkg::QPTR_W'(b2pb_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= '{value: value_i, count: count_sat};
    end
  end

endmodule

// ----- design/b2pb_back.sv -----
module b2pb_back #(
  parameter int unsigned MAX_BYTES = b2pb_pkg::MaxBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  b2pb_pkg::item_t             q_item_i,
  output logic                        q_take_o,
  output logic                        empty,
  input  logic                        pop,
  output logic [b2pb_pkg::BYTE_W-1:0] bcd_byte_o,
  output logic                        last_o
);

  localparam int unsigned DIGITS = 2 * MAX_BYTES;
  localparam int unsigned BCD_W  = DIGITS * b2pb_pkg::DIGIT_W;
  localparam int unsigned IDX_W  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  state_e                              state_q;
  logic [b2pb_pkg::VALUE_W-1:0]        shift_q;
  logic [BCD_W-1:0]                    bcd_q;
  logic [b2pb_pkg::STEP_W-1:0]         step_q;
  logic [IDX_W-1:0]                    idx_q;
  logic [b2pb_pkg::COUNT_W-1:0]        count_q;
  logic                                out_valid_q;
  logic [b2pb_pkg::BYTE_W-1:0]         out_byte_q;
  logic                                out_last_q;

  logic [BCD_W-1:0]                    dab_bcd;
  logic [b2pb_pkg::VALUE_W-1:0]        dab_shift;
  logic [b2pb_pkg::BYTE_W-1:0]         sel_byte;
  logic                                out_free;
  logic                                emit_fire;

  assign q_take_o   = (state_q == ST_IDLE);
  assign empty      = !out_valid_q;
  assign bcd_byte_o = out_byte_q;
  assign last_o     = out_last_q;
  assign out_free   = !out_valid_q || pop;
  assign emit_fire  = (state_q == ST_EMIT) && out_free;

  // Shift-and-add-3 over several input bits. Digits above the buffer width fall off the
  // top, which leaves exactly the value modulo a power of ten.
  always_comb begin
    dab_bcd   = bcd_q;
    dab_shift = shift_q;
    for (int j = 0; j < int'(b2pb_pkg::BITS_PER_STEP); j++) begin
      for (int i = 0; i < int'(DIGITS); i++) begin
        if (dab_bcd[i*b2pb_pkg::DIGIT_W +: b2pb_pkg::DIGIT_W] >= 4'd5) begin
          dab_bcd[i*b2pb_pkg::DIGIT_W +: b2pb_pkg::DIGIT_W] =
            dab_bcd[i*b2pb_pkg::DIGIT_W +: b2pb_pkg::DIGIT_W] + 4'd3;
        end
      end
      dab_bcd   = {dab_bcd[BCD_W-2:0], dab_shift[b2pb_pkg::VALUE_W-1]};
      dab_shift = {dab_shift[b2pb_pkg::VALUE_W-2:0], 1'b0};
    end
  end

  always_comb begin
    sel_byte = '0;
    for (int i = 0; i < int'(MAX_BYTES); i++) begin
      if (idx_q == IDX_W'(i)) begin
        sel_byte = bcd_q[i*b2pb_pkg::BYTE_W +: b2pb_pkg::BYTE_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      shift_q     <= '0;
      bcd_q       <= '0;
      step_q      <= '0;
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            shift_q <= q_item_i.value;
            count_q <= q_item_i.count;
            bcd_q   <= '0;
            step_q  <= '0;
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd_q   <= dab_bcd;
          shift_q <= dab_shift;
          step_q  <= step_q + 1'b1;
          if (step_q == b2pb_pkg::STEP_W'(b2pb_pkg::DAB_STEPS - 1)) begin
            idx_q   <= IDX_W'(count_q - 1'b1);
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_byte_q  <= sel_byte;
            out_last_q  <= (idx_q == '0);
            if (idx_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q - 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/binary_to_packed_bcd.sv -----
// Binary to packed BCD converter. Each input beat carries a 64-bit value and a byte
// count n (clamped to MAX_BYTES; a count of zero is taken and produces nothing). The
// block returns n output beats, most significant byte first, two decimal digits per
// byte with the higher digit in the upper nibble, and last set on the final one; the
// bytes hold the value modulo 100^n. A two-entry input queue takes new beats while an
// earlier one is converted. Conversion is shift-and-add-3 over eight bits per cycle. An
// item is loaded from the queue when the converter is idle, converted in the conversion
// state, and then handed out byte by byte through the output register as bytes are popped.
// The output register lets the next item start while the final byte still waits.
module binary_to_packed_bcd #(
  parameter int unsigned MAX_BYTES = b2pb_pkg::MaxBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [b2pb_pkg::VALUE_W-1:0] value_i,
  input  logic [b2pb_pkg::COUNT_W-1:0] byte_count_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [b2pb_pkg::BYTE_W-1:0]  bcd_byte_o,
  output logic                         last_o
);

  logic            q_valid;
  logic            q_take;
  b2pb_pkg::item_t q_item;

  b2pb_front #(
    .MAX_BYTES (MAX_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .value_i      (value_i),
    .byte_count_i (byte_count_i),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item),
    .q_take_i     (q_take)
  );

  b2pb_back #(
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_take_o   (q_take),
    .empty      (empty),
    .pop        (pop),
    .bcd_byte_o (bcd_byte_o),
    .last_o     (last_o)
  );

endmodule
